@@ src/clrs_pkg.sv @@
// shared types and constants of the channel load rate selector
package clrs_pkg;

   localparam int TIMER_BITS    = 20;
   localparam int FRACTION_BITS = 10;
   localparam int RATIO_BITS    = FRACTION_BITS + 1;
   localparam int REM_BITS      = TIMER_BITS + 1;
   localparam int STEP_BITS     = $clog2(RATIO_BITS);
   localparam int THRESH_BITS   = 11;
   localparam int TABLE_BITS    = 16;
   localparam int CODE_BITS     = 4;
   localparam int DEC_BITS      = 3;
   localparam int INDEX_BITS    = 3;
   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 32;

   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(RATIO_BITS - 1);

   localparam logic [TIMER_BITS-1:0]  MEAS_INT_RESET = TIMER_BITS'(1000);
   localparam logic [TIMER_BITS-1:0]  DEC_INT_RESET  = TIMER_BITS'(1000);
   localparam logic [THRESH_BITS-1:0] LOAD_HIGH_RESET = THRESH_BITS'(614);
   localparam logic [THRESH_BITS-1:0] LOAD_REF_RESET  = THRESH_BITS'(410);
   localparam logic [THRESH_BITS-1:0] LOAD_LOW_RESET  = THRESH_BITS'(154);

   typedef enum logic [INDEX_BITS-1:0] {
      REG_MEASURE_INTERVAL  = 3'd0,
      REG_DECISION_INTERVAL = 3'd1,
      REG_LOAD_HIGH         = 3'd2,
      REG_LOAD_REF          = 3'd3,
      REG_LOAD_LOW          = 3'd4,
      REG_MCS_TABLE         = 3'd5
   } reg_index_type;

   typedef enum logic [DEC_BITS-1:0] {
      DEC_NONE      = 3'd0,
      DEC_HIGH      = 3'd1,
      DEC_MEDIUM    = 3'd2,
      DEC_LOW       = 3'd3,
      DEC_VERY_LOW  = 3'd4
   } decision_type;

   typedef enum logic [1:0] {
      ST_READY  = 2'd0,
      ST_DIVIDE = 2'd1,
      ST_DECIDE = 2'd2
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic tick;
      logic div_step;
      logic win_push;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic meas_fire;
      logic dec_fire;
      logic filled;
      logic out_full;
   } status_type;

endpackage

@@ src/clrs_datapath.sv @@
// datapath: config registers, timers, busy counter, ratio divider, window and result register
module clrs_datapath
   import clrs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               sts,
   input  logic                     channel_busy,
   input  logic                     csr_write,
   input  logic [INDEX_BITS-1:0]    csr_index,
   input  logic [TIMER_BITS-1:0]    csr_data,
   input  logic                     rsp_take,
   output logic                     rsp_valid,
   output logic [DEC_BITS-1:0]      rsp_decision,
   output logic [CODE_BITS-1:0]     rsp_mcs_code,
   output logic [RATIO_BITS-1:0]    rsp_load_min,
   output logic [RATIO_BITS-1:0]    rsp_load_max
);

   logic [TIMER_BITS-1:0]  meas_int_ff, meas_int_in;
   logic [TIMER_BITS-1:0]  dec_int_ff, dec_int_in;
   logic [THRESH_BITS-1:0] load_high_ff, load_high_in;
   logic [THRESH_BITS-1:0] load_ref_ff, load_ref_in;
   logic [THRESH_BITS-1:0] load_low_ff, load_low_in;
   logic [TABLE_BITS-1:0]  mcs_table_ff, mcs_table_in;

   logic [TIMER_BITS-1:0]  busy_ff, busy_in;
   logic [TIMER_BITS-1:0]  mtimer_ff, mtimer_in;
   logic [TIMER_BITS-1:0]  dtimer_ff, dtimer_in;
   logic [RATIO_BITS-1:0]  ratio_ff, ratio_in;
   logic                   filled_ff, filled_in;

   logic [REM_BITS-1:0]    div_rem_ff, div_rem_in;
   logic [TIMER_BITS-1:0]  div_den_ff, div_den_in;
   logic [RATIO_BITS-1:0]  div_quo_ff, div_quo_in;

   logic                   out_valid_ff, out_valid_in;
   logic [DEC_BITS-1:0]    out_dec_ff, out_dec_in;
   logic [CODE_BITS-1:0]   out_code_ff, out_code_in;
   logic [RATIO_BITS-1:0]  out_ratio_ff, out_ratio_in;

   logic [TIMER_BITS-1:0]  busy_inc, mt_inc, dt_inc, meas_lim, dec_lim, elapsed;
   logic                   meas_fire, dec_fire;
   logic [REM_BITS-1:0]    den_ext, rem_diff, rem_after;
   logic                   q_bit;
   logic [RATIO_BITS-1:0]  quo_next;
   logic [THRESH_BITS-1:0] win_min, win_max;
   decision_type           dec_sel;
   logic [CODE_BITS-1:0]   code_sel;

   // timers and interval events
   always_comb begin
      busy_inc  = busy_ff + TIMER_BITS'(channel_busy);
      mt_inc    = mtimer_ff + TIMER_BITS'(1);
      dt_inc    = dtimer_ff + TIMER_BITS'(1);
      meas_lim  = (meas_int_ff == '0) ? TIMER_BITS'(1) : meas_int_ff;
      dec_lim   = (dec_int_ff == '0) ? TIMER_BITS'(1) : dec_int_ff;
      meas_fire = (mt_inc >= meas_lim) || (mt_inc == '0);
      dec_fire  = (dt_inc >= dec_lim) || (dt_inc == '0);
      elapsed   = (mt_inc == '0) ? TIMER_BITS'(1) : mt_inc;
   end

   // one quotient bit per step, restoring division
   always_comb begin
      den_ext   = {1'b0, div_den_ff};
      q_bit     = div_rem_ff >= den_ext;
      rem_diff  = div_rem_ff - den_ext;
      rem_after = q_bit ? rem_diff : div_rem_ff;
      quo_next  = {div_quo_ff[RATIO_BITS-2:0], q_bit};
   end

   // load level rules on the window extremes
   always_comb begin
      win_min  = ratio_ff;
      win_max  = ratio_ff;
      dec_sel  = DEC_NONE;
      code_sel = '0;
      priority if (win_min >= load_high_ff) begin
         dec_sel  = DEC_HIGH;
         code_sel = mcs_table_ff[15:12];
      end else if (win_max < load_high_ff && win_min >= load_ref_ff) begin
         dec_sel  = DEC_MEDIUM;
         code_sel = mcs_table_ff[11:8];
      end else if (win_max < load_ref_ff && win_min >= load_low_ff) begin
         dec_sel  = DEC_LOW;
         code_sel = mcs_table_ff[3:0];
      end else if (win_max < load_ref_ff) begin
         dec_sel  = DEC_VERY_LOW;
         code_sel = mcs_table_ff[7:4];
      end
   end

   always_comb begin
      meas_int_in  = meas_int_ff;
      dec_int_in   = dec_int_ff;
      load_high_in = load_high_ff;
      load_ref_in  = load_ref_ff;
      load_low_in  = load_low_ff;
      mcs_table_in = mcs_table_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_MEASURE_INTERVAL:  meas_int_in  = csr_data;
            REG_DECISION_INTERVAL: dec_int_in   = csr_data;
            REG_LOAD_HIGH:         load_high_in = csr_data[THRESH_BITS-1:0];
            REG_LOAD_REF:          load_ref_in  = csr_data[THRESH_BITS-1:0];
            REG_LOAD_LOW:          load_low_in  = csr_data[THRESH_BITS-1:0];
            REG_MCS_TABLE:         mcs_table_in = csr_data[TABLE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      busy_in    = busy_ff;
      mtimer_in  = mtimer_ff;
      dtimer_in  = dtimer_ff;
      div_rem_in = div_rem_ff;
      div_den_in = div_den_ff;
      div_quo_in = div_quo_ff;
      ratio_in   = ratio_ff;
      filled_in  = filled_ff;
      if (cmd.tick) begin
         busy_in   = meas_fire ? '0 : busy_inc;
         mtimer_in = meas_fire ? '0 : mt_inc;
         dtimer_in = dec_fire ? '0 : dt_inc;
         if (meas_fire) begin
            div_rem_in = {1'b0, busy_inc};
            div_den_in = elapsed;
            div_quo_in = '0;
         end
      end
      if (cmd.div_step) begin
         div_rem_in = {rem_after[REM_BITS-2:0], 1'b0};
         div_quo_in = quo_next;
      end
      if (cmd.win_push) begin
         ratio_in  = quo_next;
         filled_in = 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_dec_in   = out_dec_ff;
      out_code_in  = out_code_ff;
      out_ratio_in = out_ratio_ff;
      if (rsp_take) begin
         out_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
         out_dec_in   = dec_sel;
         out_code_in  = code_sel;
         out_ratio_in = ratio_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meas_int_ff  <= MEAS_INT_RESET;
         dec_int_ff   <= DEC_INT_RESET;
         load_high_ff <= LOAD_HIGH_RESET;
         load_ref_ff  <= LOAD_REF_RESET;
         load_low_ff  <= LOAD_LOW_RESET;
         mcs_table_ff <= '0;
         busy_ff      <= '0;
         mtimer_ff    <= '0;
         dtimer_ff    <= '0;
         ratio_ff     <= '0;
         filled_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         meas_int_ff  <= meas_int_in;
         dec_int_ff   <= dec_int_in;
         load_high_ff <= load_high_in;
         load_ref_ff  <= load_ref_in;
         load_low_ff  <= load_low_in;
         mcs_table_ff <= mcs_table_in;
         busy_ff      <= busy_in;
         mtimer_ff    <= mtimer_in;
         dtimer_ff    <= dtimer_in;
         ratio_ff     <= ratio_in;
         filled_ff    <= filled_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_rem_ff   <= div_rem_in;
      div_den_ff   <= div_den_in;
      div_quo_ff   <= div_quo_in;
      out_dec_ff   <= out_dec_in;
      out_code_ff  <= out_code_in;
      out_ratio_ff <= out_ratio_in;
   end

   always_comb begin
      sts.meas_fire = meas_fire;
      sts.dec_fire  = dec_fire;
      sts.filled    = filled_ff;
      sts.out_full  = out_valid_ff;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_decision = out_dec_ff;
   assign rsp_mcs_code = out_code_ff;
   assign rsp_load_min = out_ratio_ff;
   assign rsp_load_max = out_ratio_ff;

   // the ratio never exceeds one whole
   assert property (@(posedge clock) disable iff (reset)
      cmd.win_push |=> ratio_ff <= RATIO_BITS'(1 << FRACTION_BITS))
      else $error("busy ratio above full scale");

   // busy ticks never outrun elapsed ticks
   assert property (@(posedge clock) disable iff (reset) busy_ff <= mtimer_ff)
      else $error("busy count exceeds measure timer");

   // no word is presented before the first ratio sample
   assert property (@(posedge clock) disable iff (reset) out_valid_ff |-> filled_ff)
      else $error("result without window sample");

endmodule

@@ src/clrs_controller.sv @@
// controller: tick acceptance, divider sequencing and result hand-off
module clrs_controller
   import clrs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type sts,
   output cmd_type    cmd
);

   state_type             state_ff, state_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  pend_ff, pend_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_READY;
         step_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         pend_ff  <= pend_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      pend_in      = pend_ff;
      req_ready    = 1'b0;
      cmd.tick     = 1'b0;
      cmd.div_step = 1'b0;
      cmd.win_push = 1'b0;
      cmd.out_load = 1'b0;
      unique case (state_ff)
         ST_READY: begin
            // a decision that needs the result register waits for it to drain
            req_ready = !(sts.dec_fire && !sts.meas_fire && sts.out_full);
            if (req_valid && req_ready) begin
               cmd.tick = 1'b1;
               if (sts.meas_fire) begin
                  state_in = ST_DIVIDE;
                  step_in  = '0;
                  pend_in  = sts.dec_fire;
               end else if (sts.dec_fire && sts.filled) begin
                  cmd.out_load = 1'b1;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_BITS'(1);
            if (step_ff == LAST_STEP) begin
               cmd.win_push = 1'b1;
               step_in      = '0;
               state_in     = pend_ff ? ST_DECIDE : ST_READY;
            end
         end
         ST_DECIDE: begin
            if (!sts.out_full) begin
               cmd.out_load = 1'b1;
               pend_in      = 1'b0;
               state_in     = ST_READY;
            end
         end
         default: state_in = ST_READY;
      endcase
   end

   // the result register is only loaded when empty
   assert property (@(posedge clock) disable iff (reset) cmd.out_load |-> !sts.out_full)
      else $error("result overwritten");

   // a tick closing a measurement starts the divider
   assert property (@(posedge clock) disable iff (reset)
      cmd.tick && sts.meas_fire |=> state_ff == ST_DIVIDE && step_ff == '0)
      else $error("divider not started");

   // a window push ends the divide sequence
   assert property (@(posedge clock) disable iff (reset)
      cmd.win_push |=> state_ff == ST_READY || state_ff == ST_DECIDE)
      else $error("divide sequence did not end");

endmodule

@@ src/channel_load_rate_selector_unit.sv @@
// top level of the channel load rate selector
// One tick is taken per cycle. A tick that closes a measure interval starts
// a restoring divider (one quotient bit per cycle) that turns the busy count
// into a ratio in 1/1024 units, and no tick is taken until it has finished;
// when it also closes a decision interval, the result word is written after
// the divide. Once a ratio exists, a tick that closes a decision interval
// writes one result word into the output register; while that register
// still holds an untaken word, such a tick, or the write after a divide, waits.
// Configuration writes are taken every cycle and are meant for when the
// block is idle.
module channel_load_rate_selector_unit
   import clrs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,  // channel_busy
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // decision[2:0], mcs_code[6:3], load_min[17:7], load_max[28:18], zeros above
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [INDEX_BITS-1:0]     csr_index,
   input  logic [TIMER_BITS-1:0]     csr_data
);

   cmd_type               cmd;
   status_type            sts;
   logic [DEC_BITS-1:0]   rsp_decision;
   logic [CODE_BITS-1:0]  rsp_mcs_code;
   logic [RATIO_BITS-1:0] rsp_load_min, rsp_load_max;

   assign csr_ready = 1'b1;

   clrs_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   clrs_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .channel_busy (req_tdata[0]),
      .csr_write    (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_take     (rsp_tvalid && rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_decision (rsp_decision),
      .rsp_mcs_code (rsp_mcs_code),
      .rsp_load_min (rsp_load_min),
      .rsp_load_max (rsp_load_max)
   );

   assign rsp_tdata = {3'b000, rsp_load_max, rsp_load_min, rsp_mcs_code, rsp_decision};

endmodule

@@ test/tb_channel_load_rate_selector_unit.sv @@
`timescale 1ns / 1ps
// self-checking bench for the channel load rate selector: busy ticks in, rate choices checked
module tb_channel_load_rate_selector_unit;
   import clrs_pkg::*;

   typedef struct packed {
      decision_type           level;
      logic [CODE_BITS-1:0]   code;
      logic [THRESH_BITS-1:0] load_min;
      logic [THRESH_BITS-1:0] load_max;
   } rate_choice_type;

   // a measuring tick holds the block until its divide, and any decision after it, is done
   localparam int SETTLE_CYCLES = 40;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [INDEX_BITS-1:0]    csr_index = '0;
   logic [TIMER_BITS-1:0]    csr_data = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int failures = 0;
   rate_choice_type pending_choices[$];
   rate_choice_type oldest_choice;

   // shadow copy of the registers
   logic [TIMER_BITS-1:0]  meas_period;
   logic [TIMER_BITS-1:0]  dec_period;
   logic [THRESH_BITS-1:0] thr_high;
   logic [THRESH_BITS-1:0] thr_ref;
   logic [THRESH_BITS-1:0] thr_low;
   logic [TABLE_BITS-1:0]  code_table;

   // shadow copy of the measurement state
   logic [TIMER_BITS-1:0]  busy_count;
   logic [TIMER_BITS-1:0]  meas_age;
   logic [TIMER_BITS-1:0]  dec_age;
   logic [31:0]            last_ratio;
   logic                   ratio_seen;

   channel_load_rate_selector_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // channel_busy
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // decision, mcs_code, load_min, load_max
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

   // advance the shadow state by one tick and queue the choice it makes
   function automatic void advance_load_model(input logic busy);
      logic [TIMER_BITS-1:0] mi;
      logic [TIMER_BITS-1:0] di;
      logic [TIMER_BITS-1:0] elapsed;
      logic [31:0]           lo;
      logic [31:0]           hi;
      rate_choice_type       choice;
      mi = (meas_period == '0) ? TIMER_BITS'(1) : meas_period;
      di = (dec_period == '0) ? TIMER_BITS'(1) : dec_period;
      if (busy) busy_count = busy_count + 1'b1;
      meas_age = meas_age + 1'b1;
      dec_age = dec_age + 1'b1;
      // measurement goes first when both fall on one tick
      if (meas_age >= mi || meas_age == '0) begin
         elapsed = (meas_age == '0) ? TIMER_BITS'(1) : meas_age;
         last_ratio = (32'(busy_count) << FRACTION_BITS) / 32'(elapsed);
         ratio_seen = 1'b1;
         busy_count = '0;
         meas_age = '0;
      end
      if (dec_age >= di || dec_age == '0) begin
         dec_age = '0;
         if (ratio_seen) begin
            lo = last_ratio;
            hi = last_ratio;
            choice.load_min = lo[THRESH_BITS-1:0];
            choice.load_max = hi[THRESH_BITS-1:0];
            if (lo >= thr_high) begin
               choice.level = DEC_HIGH;
               choice.code = code_table[15:12];
            end else if (hi < thr_high && lo >= thr_ref) begin
               choice.level = DEC_MEDIUM;
               choice.code = code_table[11:8];
            end else if (hi < thr_ref && lo >= thr_low) begin
               choice.level = DEC_LOW;
               choice.code = code_table[3:0];
            end else if (hi < thr_ref) begin
               choice.level = DEC_VERY_LOW;
               choice.code = code_table[7:4];
            end else begin
               choice.level = DEC_NONE;
               choice.code = '0;
            end
            pending_choices.push_back(choice);
         end
      end
   endfunction

   // leaves csr_valid high so back-to-back writes need no extra step
   task automatic write_reg(input reg_index_type idx, input logic [TIMER_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_MEASURE_INTERVAL:  meas_period = value;
         REG_DECISION_INTERVAL: dec_period = value;
         REG_LOAD_HIGH:         thr_high = value[THRESH_BITS-1:0];
         REG_LOAD_REF:          thr_ref = value[THRESH_BITS-1:0];
         REG_LOAD_LOW:          thr_low = value[THRESH_BITS-1:0];
         REG_MCS_TABLE:         code_table = value[TABLE_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [TIMER_BITS-1:0] mi, input logic [TIMER_BITS-1:0] di,
                            input logic [THRESH_BITS-1:0] hi, input logic [THRESH_BITS-1:0] rf,
                            input logic [THRESH_BITS-1:0] lo, input logic [TABLE_BITS-1:0] tbl);
      write_reg(REG_MEASURE_INTERVAL, mi);
      write_reg(REG_DECISION_INTERVAL, di);
      write_reg(REG_LOAD_HIGH, TIMER_BITS'(hi));
      write_reg(REG_LOAD_REF, TIMER_BITS'(rf));
      write_reg(REG_LOAD_LOW, TIMER_BITS'(lo));
      write_reg(REG_MCS_TABLE, TIMER_BITS'(tbl));
      csr_valid <= 1'b0;
   endtask

   task automatic send_tick(input logic busy);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_BITS'(busy);
      do @(posedge clock); while (!req_tready);
      advance_load_model(busy);
   endtask

   // stop sending, collect every pending word, then let a divide finish
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_choices.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // decisions before the first measurement give no word; thresholds at reset values
   task automatic test_empty_window();
      logic [11:0] pattern;
      pattern = 12'b1011_0110_1110;
      write_reg(REG_MEASURE_INTERVAL, 20'd4);
      write_reg(REG_DECISION_INTERVAL, 20'd3);
      csr_valid <= 1'b0;
      foreach (pattern[i]) send_tick(pattern[i]);
      settle();
   endtask

   task automatic test_load_levels();
      logic [7:0] pattern;
      pattern = 8'b1100_1000;
      configure(20'd4, 20'd4, 11'd614, 11'd410, 11'd154, 16'hC5A3);
      // half busy gives medium, a quarter busy gives low
      foreach (pattern[i]) send_tick(pattern[i]);
      settle();
   endtask

   task automatic test_threshold_extremes();
      configure(20'd1, 20'd1, 11'd1024, 11'd1023, 11'd1024, 16'hFFFF);
      send_tick(1'b1);
      send_tick(1'b0);
      settle();
      configure(20'd1, 20'd1, 11'd0, 11'd0, 11'd0, 16'h0000);
      send_tick(1'b0);
      send_tick(1'b1);
      settle();
   endtask

   // shrinking an interval under the running timer fires on the next tick
   task automatic test_lowered_interval();
      configure(20'hFFFFF, 20'hFFFFF, 11'd600, 11'd300, 11'd100, 16'h9E17);
      repeat (12) send_tick(1'($urandom_range(1)));
      settle();
      write_reg(REG_MEASURE_INTERVAL, 20'd5);
      write_reg(REG_DECISION_INTERVAL, 20'd3);
      csr_valid <= 1'b0;
      repeat (6) send_tick(1'($urandom_range(1)));
      settle();
   endtask

   function automatic logic [TIMER_BITS-1:0] pick_interval();
      return ($urandom_range(9) == 0) ? TIMER_BITS'($urandom_range(64, 1))
                                      : TIMER_BITS'($urandom_range(12, 1));
   endfunction

   task automatic test_random_traffic();
      int                     busy_pct;
      logic [THRESH_BITS-1:0] lo;
      logic [THRESH_BITS-1:0] rf;
      logic [THRESH_BITS-1:0] hi;
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 24;
               recv_idle_pct = 78;
            end
            1: begin
               send_idle_pct = 78;
               recv_idle_pct = 24;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int setting = 0; setting < 5; setting++) begin
            // mostly ordered thresholds so every level shows up
            if ($urandom_range(3) != 0) begin
               lo = THRESH_BITS'($urandom_range(600));
               rf = THRESH_BITS'(32'(lo) + $urandom_range(300));
               hi = THRESH_BITS'(32'(rf) + $urandom_range(1024 - 32'(rf)));
            end else begin
               lo = THRESH_BITS'($urandom_range(1024));
               rf = THRESH_BITS'($urandom_range(1024));
               hi = THRESH_BITS'($urandom_range(1024));
            end
            configure(pick_interval(), pick_interval(), hi, rf, lo,
                      TABLE_BITS'($urandom_range(16'hFFFF)));
            busy_pct = $urandom_range(100);
            repeat (54) send_tick($urandom_range(99) < busy_pct);
            settle();
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_choices.size() == 0) begin
               $error("result word with no decision pending: %h", rsp_tdata);
               failures++;
            end else begin
               oldest_choice = pending_choices.pop_front();
               if (rsp_tdata[2:0] !== oldest_choice.level) begin
                  $error("decision: expected %0d, got %0d", oldest_choice.level, rsp_tdata[2:0]);
                  failures++;
               end
               if (rsp_tdata[6:3] !== oldest_choice.code) begin
                  $error("mcs_code: expected %0d, got %0d", oldest_choice.code, rsp_tdata[6:3]);
                  failures++;
               end
               if (rsp_tdata[17:7] !== oldest_choice.load_min) begin
                  $error("load_min: expected %0d, got %0d", oldest_choice.load_min,
                         rsp_tdata[17:7]);
                  failures++;
               end
               if (rsp_tdata[28:18] !== oldest_choice.load_max) begin
                  $error("load_max: expected %0d, got %0d", oldest_choice.load_max,
                         rsp_tdata[28:18]);
                  failures++;
               end
               if (rsp_tdata[31:29] !== 3'b000) begin
                  $error("padding: expected 0, got %0d", rsp_tdata[31:29]);
                  failures++;
               end
            end
         end
      end
   end

   initial begin
      meas_period = MEAS_INT_RESET;
      dec_period = DEC_INT_RESET;
      thr_high = LOAD_HIGH_RESET;
      thr_ref = LOAD_REF_RESET;
      thr_low = LOAD_LOW_RESET;
      code_table = '0;
      busy_count = '0;
      meas_age = '0;
      dec_age = '0;
      last_ratio = '0;
      ratio_seen = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_window();
      test_load_levels();
      test_threshold_extremes();
      test_lowered_interval();
      test_random_traffic();
      settle();
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
